[rtl/nos_pkg.sv]
// Shared types and constants for the nearest obstacle selector.
package nos_pkg;

	localparam int COORD_W = 24;
	localparam int KEY_W = 48;
	localparam int RANK_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam logic signed [COORD_W-1:0] PAD_RESET = 24'sd256000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [KEY_W-1:0] key_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		coord_t x;
		coord_t y;
		key_t key;
		logic has_point;
		logic end_of_cloud;
	} entry_t;

	// Queue write side, driven by the front
	typedef struct packed {
		logic valid;
		entry_t entry;
	} push_t;

	// Queue read side, seen by the back
	typedef struct packed {
		logic valid;
		entry_t entry;
	} head_t;

endpackage

[rtl/nos_if.sv]
// Handshake channels for input points and ranked obstacle results.
interface nos_point_if;
	logic valid;
	logic ready;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic has_point;
	logic end_of_cloud;

	modport source (output valid, point_x, point_y, has_point, end_of_cloud, input ready);
	modport sink (input valid, point_x, point_y, has_point, end_of_cloud, output ready);
endinterface

interface nos_result_if;
	logic valid;
	logic ready;
	logic signed [23:0] near_x;
	logic signed [23:0] near_y;
	logic [2:0] rank;
	logic is_padding;
	logic last_slot;

	modport source (output valid, near_x, near_y, rank, is_padding, last_slot, input ready);
	modport sink (input valid, near_x, near_y, rank, is_padding, last_slot, output ready);
endinterface

[rtl/nos_front.sv]
// Front end: accepts items, drops empty ones and computes the distance key.
module nos_front (
	input  logic clk,
	input  logic arst_n,
	nos_point_if.sink points,
	output nos_pkg::push_t push,
	input  logic q_full
);

	logic valid_s1;
	nos_pkg::coord_t x_s1;
	nos_pkg::coord_t y_s1;
	logic has_point_s1;
	logic end_s1;

	logic valid_s2;
	nos_pkg::coord_t x_s2;
	nos_pkg::coord_t y_s2;
	logic has_point_s2;
	logic end_s2;
	nos_pkg::key_t sq_x_s2;
	nos_pkg::key_t sq_y_s2;

	logic [nos_pkg::COORD_W-1:0] mag_x;
	logic [nos_pkg::COORD_W-1:0] mag_y;
	logic adv_s2;
	logic adv_s1;
	logic take;

	// Stage handshakes: a stage moves when the one after it has room
	assign adv_s2 = !valid_s2 || !q_full;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign points.ready = adv_s1;
	assign take = points.valid && adv_s1;

	// Absolute values of the registered coordinates
	assign mag_x = x_s1[nos_pkg::COORD_W-1] ? nos_pkg::COORD_W'(-x_s1) : x_s1;
	assign mag_y = y_s1[nos_pkg::COORD_W-1] ? nos_pkg::COORD_W'(-y_s1) : y_s1;

	// Stage 1 control: items with neither point nor end are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= take && (points.has_point || points.end_of_cloud);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= points.point_x;
			y_s1 <= points.point_y;
			has_point_s1 <= points.has_point;
			end_s1 <= points.end_of_cloud;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: square each magnitude
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			has_point_s2 <= has_point_s1;
			end_s2 <= end_s1;
			sq_x_s2 <= mag_x * mag_x;
			sq_y_s2 <= mag_y * mag_y;
		end
	end

	// Sum the squares on the way into the queue
	always_comb begin
		push.valid = valid_s2 && !q_full;
		push.entry.x = x_s2;
		push.entry.y = y_s2;
		push.entry.key = sq_x_s2 + sq_y_s2;
		push.entry.has_point = has_point_s2;
		push.entry.end_of_cloud = end_s2;
	end

endmodule

[rtl/nos_queue.sv]
// Short queue that decouples the front end from the slot list.
module nos_queue (
	input  logic clk,
	input  logic arst_n,
	input  nos_pkg::push_t push,
	output logic full,
	output nos_pkg::head_t head,
	input  logic pop
);

	nos_pkg::entry_t mem_q [nos_pkg::QUEUE_DEPTH];
	logic [nos_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [nos_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [nos_pkg::QPTR_W:0] count_q;
	logic do_pop;

	assign full = count_q == (nos_pkg::QPTR_W+1)'(nos_pkg::QUEUE_DEPTH);
	assign do_pop = pop && (count_q != '0);

	always_comb begin
		head.valid = count_q != '0;
		head.entry = mem_q[rd_ptr_q];
	end

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/nos_back.sv]
// Back end: sorted slot list, insertion and ranked emission at end of cloud.
module nos_back #(
	parameter int SLOTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  nos_pkg::head_t head,
	output logic pop,
	input  logic cfg_we,
	input  logic signed [23:0] cfg_data,
	nos_result_if.source obstacles
);

	localparam int KW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] count_q;
	nos_pkg::coord_t pad_q;
	nos_pkg::coord_t slot_x_q [SLOTS];
	nos_pkg::coord_t slot_y_q [SLOTS];
	nos_pkg::key_t slot_key_q [SLOTS];

	logic [SLOTS-1:0] after;
	logic insert;
	logic load;
	logic is_pad;
	logic at_last;

	assign pop = (state_q == ST_IDLE) && head.valid;
	assign insert = pop && head.entry.has_point;
	assign load = !obstacles.valid || obstacles.ready;
	assign at_last = k_q == KW'(SLOTS - 1);
	assign is_pad = CW'(k_q) >= count_q;

	// Mark slots the new point goes ahead of: unfilled or strictly farther
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			after[i] = (CW'(i) >= count_q) || (slot_key_q[i] > head.entry.key);
		end
	end

	// Shift the tail down one place and drop the new point into the gap
	always_ff @(posedge clk) begin
		if (insert) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (after[i]) begin
					if (i == 0 || !after[(i == 0) ? 0 : i-1]) begin
						slot_x_q[i] <= head.entry.x;
						slot_y_q[i] <= head.entry.y;
						slot_key_q[i] <= head.entry.key;
					end else begin
						slot_x_q[i] <= slot_x_q[(i == 0) ? 0 : i-1];
						slot_y_q[i] <= slot_y_q[(i == 0) ? 0 : i-1];
						slot_key_q[i] <= slot_key_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	end

	// Pad coordinate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= nos_pkg::PAD_RESET;
		end else if (cfg_we) begin
			pad_q <= cfg_data;
		end
	end

	// Sequencer: take items while idle, walk the slots while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (insert && (count_q != CW'(SLOTS))) begin
						count_q <= count_q + 1'b1;
					end
					if (pop && head.entry.end_of_cloud) begin
						state_q <= ST_EMIT;
						k_q <= '0;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (at_last) begin
							state_q <= ST_IDLE;
							k_q <= '0;
							count_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacles.valid <= 1'b0;
		end else if (load) begin
			obstacles.valid <= state_q == ST_EMIT;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load && (state_q == ST_EMIT)) begin
			obstacles.near_x <= is_pad ? pad_q : slot_x_q[k_q];
			obstacles.near_y <= is_pad ? pad_q : slot_y_q[k_q];
			obstacles.rank <= nos_pkg::RANK_W'(k_q);
			obstacles.is_padding <= is_pad;
			obstacles.last_slot <= at_last;
		end
	end

endmodule

[rtl/nearest_obstacle_select.sv]
// A point passes stage 1, stage 2 and the queue on its way to the slot list.
// Throughput: one point per cycle while the queue has room and the slot list is
// idle; an end-of-cloud item holds the slot list while the ranked list leaves
// through the single output register once the sequencer enters its emit state.
// Reset empties the list and the queue and loads the pad coordinate with 1000 m.
module nearest_obstacle_select #(
	parameter int SLOTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	nos_point_if.sink points,
	nos_result_if.source obstacles,
	input  logic cfg_we,
	input  logic signed [23:0] cfg_data
);

	nos_pkg::push_t push;
	nos_pkg::head_t head;
	logic q_full;
	logic pop;

	// Accept and classify
	nos_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points),
		.push   (push),
		.q_full (q_full)
	);

	// Decouple
	nos_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// Rank and emit
	nos_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.obstacles (obstacles)
	);

endmodule
